>>> rtl/lhagc_pkg.sv
// ----------------------------------------------------------------------------
// lhagc_pkg
// Shared types and constants for the look-ahead hang AGC.
// ----------------------------------------------------------------------------
package lhagc_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REFERENCE = 3'd0,
        REG_ATTACK    = 3'd1,
        REG_DECAY     = 3'd2,
        REG_CEILING   = 3'd3,
        REG_START     = 3'd4,
        REG_HOLD      = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [16:0] a;
        logic [31:0] b;
    } t_mul_req;
endpackage

>>> rtl/lhagc_ram.sv
// ----------------------------------------------------------------------------
// lhagc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module lhagc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/lhagc_mul.sv
// ----------------------------------------------------------------------------
// lhagc_mul
// Bit-serial multiplier: 17 x 32 unsigned, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lhagc_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lhagc_pkg::t_mul_req i_req,
    output logic               o_done,
    output logic [48:0]        o_prod
);
    import lhagc_pkg::*;

    logic [48:0] r_acc, n_acc;
    logic [16:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // add the shifted multiplicand for the current multiplier bit
            if (r_a[0]) begin
                n_acc = r_acc + ({17'd0, r_b} << r_cnt);
            end
            n_a   = r_a >> 1;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd16) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    property p_done_pulse;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |=> !o_done;
    endproperty
    a_done_pulse: assert property (p_done_pulse) else $error("done not a pulse");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("done without work");

    property p_idle_no_done;
        @(posedge i_clk) disable iff (!i_rst_n) (!r_busy && !i_req.start) |=> !o_done;
    endproperty
    a_idle_no_done: assert property (p_idle_no_done) else $error("spurious done");
endmodule

>>> rtl/lookahead_hang_agc.sv
// ----------------------------------------------------------------------------
// lookahead_hang_agc
// AGC with look-ahead peak and hang time on signed 16-bit samples.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  input    | in        | i_valid / o_stall   | i_sample_in[15:0]
//  output   | out       | o_valid / i_stall   | o_sample_out[15:0]
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  During fill a sample gets a peak rescan over the circular line RAM, one
//  entry per cycle. A full-line sample takes three passes of the bit-serial
//  multiplier (peak*gain, gain*factor, sample*gain) and then the rescan.
//  Reset is synchronous; the line RAM is covered by the fill count.
//  Input stalls while a sample is in work and in the cycle after a register
//  write; an unread result is held until taken, and the next sample is
//  accepted meanwhile. Its result then waits in write-back until the output
//  register is free.
module lookahead_hang_agc #(
    parameter int unsigned AHEAD = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [15:0]            i_sample_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [15:0]            o_sample_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lhagc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lhagc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import lhagc_pkg::*;

    localparam int unsigned AW  = (AHEAD > 1) ? $clog2(AHEAD) : 1;
    localparam int unsigned FCW = $clog2(AHEAD + 1);
    localparam logic [FCW-1:0] FULL = FCW'(AHEAD);
    localparam logic [AW-1:0]  LAST = AW'(AHEAD - 1);

    // configuration
    logic [14:0] r_ref;
    logic [15:0] r_att, r_dec, r_hold_len;
    logic [31:0] r_ceil;

    // state
    t_state r_state, n_state;
    logic [31:0] r_gain;
    logic [15:0] r_hold, r_peak;
    logic [FCW-1:0] r_fill;
    logic [AW-1:0]  r_head;
    logic [AW-1:0]  r_scan;
    logic [FCW-1:0] r_scnt;
    logic           r_rvalid;
    logic [16:0]    r_max;
    logic signed [15:0] r_old, r_new;
    logic [1:0]     r_phase;
    logic [15:0]    r_out;
    logic           r_ovalid;
    logic           r_cfg_seen;

    logic           w_acc, w_full, w_we, w_out_go;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [15:0]    w_wdata;
    logic [15:0]    w_rdata;
    logic [16:0]    w_mag;
    t_mul_req       w_req;
    logic           w_mdone;
    logic [48:0]    w_prod;

    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_stall     = (r_state != ST_IDLE) || r_cfg_seen;
    assign w_acc       = i_valid && !o_stall;
    assign w_full      = (r_fill == FULL);
    assign w_out_go    = (r_state == ST_OUT) && !(r_ovalid && i_stall);
    assign o_valid     = r_ovalid;
    assign o_sample_out = r_out;

    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        mag16 = v[15] ? (17'd0 - {{1{v[15]}}, v}) : {1'b0, v};
    endfunction

    // fill: write at accept; full line: overwrite the oldest at head on write-back
    assign w_we    = (w_acc && !w_full) || w_out_go;
    assign w_waddr = r_head;
    assign w_wdata = w_out_go ? r_new : i_sample_in;
    assign w_raddr = (r_state == ST_SCAN) ? r_scan : r_head;
    assign w_mag   = mag16(w_rdata);

    lhagc_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_line (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lhagc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_acc) n_state = w_full ? ST_MUL : ST_SCAN;
            ST_MUL:  if (w_mdone && r_phase == 2'd2) n_state = ST_OUT;
            ST_OUT:  if (w_out_go) n_state = ST_SCAN;
            ST_SCAN: if (!r_rvalid && r_scnt == '0) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // multiplier requests
    always_comb begin
        w_req = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && w_full) begin
                    w_req.start = 1'b1;
                    w_req.a     = {1'b0, r_peak};
                    w_req.b     = r_gain;
                end
            end
            ST_MUL: begin
                if (w_mdone && r_phase == 2'd0) begin
                    w_req.start = 1'b1;
                    if (w_prod > {r_ref, 16'd0}) begin
                        w_req.a = 17'h10000 - {1'b0, r_att};
                    end else if (r_hold != 16'd0) begin
                        w_req.a = 17'h10000;
                    end else if (w_prod < {r_ref, 16'd0}) begin
                        w_req.a = 17'h10000 + {1'b0, r_dec};
                    end else begin
                        w_req.a = 17'h10000;
                    end
                    w_req.b = r_gain;
                end else if (w_mdone && r_phase == 2'd1) begin
                    w_req.start = 1'b1;
                    w_req.a     = mag16(r_old);
                    w_req.b     = (w_prod[48:16] > {1'b0, r_ceil}) ? r_ceil : w_prod[47:16];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ref      <= 15'd26213;
            r_att      <= 16'd6554;
            r_dec      <= 16'd66;
            r_ceil     <= 32'h0100_0000;
            r_hold_len <= 16'd200;
            r_gain     <= 32'h0001_0000;
            r_hold     <= '0;
            r_peak     <= '0;
            r_fill     <= '0;
            r_head     <= '0;
            r_ovalid   <= 1'b0;
            r_rvalid   <= 1'b0;
            r_scnt     <= '0;
            r_phase    <= '0;
            r_cfg_seen <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cfg_seen <= i_cfg_valid && o_cfg_ready;
            if (w_out_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_REFERENCE: r_ref      <= i_cfg_data[14:0];
                    REG_ATTACK:    r_att      <= i_cfg_data[15:0];
                    REG_DECAY:     r_dec      <= i_cfg_data[15:0];
                    REG_CEILING:   r_ceil     <= i_cfg_data;
                    REG_START:     r_gain     <= i_cfg_data;
                    REG_HOLD:      r_hold_len <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_new   <= i_sample_in;
                r_phase <= 2'd0;
                if (!w_full) begin
                    r_fill <= r_fill + FCW'(1);
                    r_head <= (r_head == LAST) ? '0 : r_head + AW'(1);
                end
            end
            if (r_state == ST_MUL && w_mdone) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd0) begin
                    if (w_prod > {r_ref, 16'd0}) r_hold <= r_hold_len;
                    else if (r_hold != 16'd0) r_hold <= r_hold - 16'd1;
                end else if (r_phase == 2'd1) begin
                    r_gain <= (w_prod[48:16] > {1'b0, r_ceil}) ? r_ceil : w_prod[47:16];
                end
            end
            // the last product holds while write-back waits for the output
            if (w_out_go) begin
                r_head <= (r_head == LAST) ? '0 : r_head + AW'(1);
                // saturate toward the sign of the oldest sample
                if (r_old[15]) begin
                    r_out <= (w_prod[48:16] > 33'd32768) ? 16'h8000
                             : 16'(17'd0 - w_prod[32:16]);
                end else begin
                    r_out <= (w_prod[48:16] > 33'd32767) ? 16'h7FFF : w_prod[31:16];
                end
            end
            // rescan: walk the filled entries, one read a cycle
            if (n_state == ST_SCAN && r_state != ST_SCAN) begin
                r_scnt <= w_full ? r_fill : r_fill + FCW'(1);
                r_max  <= '0;
            end
            if (r_state == ST_SCAN) begin
                r_rvalid <= (r_scnt != '0);
                if (r_scnt != '0) r_scnt <= r_scnt - FCW'(1);
                if (r_rvalid && w_mag > r_max) r_max <= w_mag;
                if (!r_rvalid && r_scnt == '0) r_peak <= r_max[15:0];
            end else begin
                r_rvalid <= 1'b0;
            end
        end
        r_scan <= (r_state == ST_SCAN) ? ((r_scan == LAST) ? '0 : r_scan + AW'(1)) : '0;
        // oldest sample sits at head; the read is settled by the first product
        if (r_state == ST_MUL && w_mdone && r_phase == 2'd0) r_old <= w_rdata;
    end

    property p_no_out_while_filling;
        @(posedge i_clk) disable iff (!i_rst_n) (!w_full && r_state == ST_IDLE) |-> !n_state[1];
    endproperty
    a_no_out_while_filling: assert property (p_no_out_while_filling)
        else $error("multiply started while filling");

    property p_gain_clamped;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_ovalid) |-> (r_gain <= r_ceil);
    endproperty
    a_gain_clamped: assert property (p_gain_clamped) else $error("gain over ceiling");

    property p_out_holds;
        @(posedge i_clk) disable iff (!i_rst_n) (o_valid && i_stall) |=> o_valid;
    endproperty
    a_out_holds: assert property (p_out_holds) else $error("result dropped");
endmodule
